/* rtl/core/prc_pkg.sv */
// Shared types, register map and reset values of the PNG region carver.
package prc_pkg;

    localparam int unsigned REG_DATA_BITS = 64;
    localparam int unsigned REG_ADDR_BITS = 5;
    localparam int unsigned REG_IDX_BITS = 2;
    localparam int unsigned OUT_OFF_BITS = 48;
    localparam int unsigned COUNT_BITS = 32;

    localparam logic [REG_IDX_BITS-1:0] REG_HEADER_SIG = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_TRAILER_SIG = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_MAX_LENGTH = 2'd2;

    localparam logic [63:0] HEADER_SIG_RESET = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [63:0] TRAILER_SIG_RESET = 64'h4945_4E44_AE42_6082;
    localparam logic [COUNT_BITS-1:0] MAX_LENGTH_RESET = 32'h0280_0000;

    localparam logic EVENT_COMPLETE = 1'b0;
    localparam logic EVENT_ABANDONED = 1'b1;

    typedef struct packed {
        logic [63:0]           header_sig;
        logic [63:0]           trailer_sig;
        logic [COUNT_BITS-1:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } item_t;

endpackage

/* rtl/core/prc_cfg_regs.sv */
// Configuration register file of the PNG region carver behind an APB-style port.
module prc_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [prc_pkg::REG_ADDR_BITS-1:0]   paddr,
    input  logic [prc_pkg::REG_DATA_BITS-1:0]   pwdata,
    output logic [prc_pkg::REG_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output prc_pkg::cfg_t                       cfg
);

    prc_pkg::cfg_t                       cfg_reg;
    logic [prc_pkg::REG_IDX_BITS-1:0]    reg_idx;
    logic                                wr_en;

    assign reg_idx = paddr[prc_pkg::REG_ADDR_BITS-1:3];
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_sig <= prc_pkg::HEADER_SIG_RESET;
            cfg_reg.trailer_sig <= prc_pkg::TRAILER_SIG_RESET;
            cfg_reg.max_length <= prc_pkg::MAX_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                prc_pkg::REG_HEADER_SIG:  cfg_reg.header_sig <= pwdata;
                prc_pkg::REG_TRAILER_SIG: cfg_reg.trailer_sig <= pwdata;
                prc_pkg::REG_MAX_LENGTH:
                    cfg_reg.max_length <= pwdata[prc_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            prc_pkg::REG_HEADER_SIG:  prdata = cfg_reg.header_sig;
            prc_pkg::REG_TRAILER_SIG: prdata = cfg_reg.trailer_sig;
            prc_pkg::REG_MAX_LENGTH:
                prdata = prc_pkg::REG_DATA_BITS'(cfg_reg.max_length);
            default: prdata = '0;
        endcase
    end

endmodule

/* rtl/core/prc_in_stage.sv */
// Input register that holds one stream byte for the scan stage.
module prc_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           data_valid,
    output logic           data_stall,
    input  logic [7:0]     data_byte,
    input  logic           advance,
    output prc_pkg::item_t item
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign data_stall = vld_reg && !advance;
    assign accept = data_valid && !data_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
        end
    end

    assign item.vld = vld_reg;
    assign item.data = byte_reg;

endmodule

/* rtl/core/prc_scan.sv */
// Signature matching, region tracking and result register of the PNG region carver.
module prc_scan
#(
    parameter int unsigned SIG_LEN = 8,
    parameter int unsigned OFFSET_BITS = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  prc_pkg::cfg_t                       cfg,
    input  prc_pkg::item_t                      item,
    output logic                                advance,
    output logic                                event_valid,
    input  logic                                event_stall,
    output logic                                event_kind,
    output logic [prc_pkg::OUT_OFF_BITS-1:0]    region_start,
    output logic [prc_pkg::OUT_OFF_BITS-1:0]    region_end
);

    localparam int unsigned WIN_BITS = 8 * SIG_LEN;
    localparam int unsigned EXT_BITS = 64;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] SIG_LEN_OFF = OFFSET_BITS'(SIG_LEN);
    localparam logic [prc_pkg::COUNT_BITS-1:0] SIG_LEN_CNT = prc_pkg::COUNT_BITS'(SIG_LEN);
    localparam logic [prc_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

    logic                             phase_reg, phase_next;
    logic [WIN_BITS-1:0]              window_reg, window_next;
    logic [OFFSET_BITS-1:0]           offset_reg, offset_next;
    logic [OFFSET_BITS-1:0]           start_reg, start_next;
    logic [prc_pkg::COUNT_BITS-1:0]   count_reg, count_next;
    logic [prc_pkg::COUNT_BITS-1:0]   count_inc;
    logic                             full;
    logic                             emit;
    logic                             emit_kind;

    logic                             out_vld_reg, out_vld_next;
    logic                             kind_reg;
    logic [prc_pkg::OUT_OFF_BITS-1:0] start_out_reg;
    logic [prc_pkg::OUT_OFF_BITS-1:0] end_out_reg;
    logic [EXT_BITS-1:0]              start_ext;
    logic [EXT_BITS-1:0]              end_ext;

    assign advance = item.vld && (!out_vld_reg || !event_stall);

    always_comb
    begin
        window_next = {window_reg[WIN_BITS-9:0], item.data};
        offset_next = (offset_reg == OFF_MAX) ? offset_reg : offset_reg + 1'b1;
        count_inc = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
        full = count_inc >= SIG_LEN_CNT;
        phase_next = phase_reg;
        start_next = start_reg;
        count_next = count_inc;
        emit = 1'b0;
        emit_kind = prc_pkg::EVENT_COMPLETE;
        if (!phase_reg)
        begin
            if (full && window_next == cfg.header_sig[WIN_BITS-1:0])
            begin
                start_next = (offset_next >= SIG_LEN_OFF) ? offset_next - SIG_LEN_OFF : '0;
                phase_next = 1'b1;
                count_next = '0;
            end
        end
        else
        begin
            priority if (full && window_next == cfg.trailer_sig[WIN_BITS-1:0])
            begin
                emit = 1'b1;
                emit_kind = prc_pkg::EVENT_COMPLETE;
                phase_next = 1'b0;
                count_next = '0;
            end
            else if (count_inc >= cfg.max_length)
            begin
                emit = 1'b1;
                emit_kind = prc_pkg::EVENT_ABANDONED;
                phase_next = 1'b0;
                count_next = '0;
            end
            else
            begin
                emit = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            window_reg <= '0;
            offset_reg <= '0;
            start_reg <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            window_reg <= window_next;
            offset_reg <= offset_next;
            start_reg <= start_next;
            count_reg <= count_next;
        end
    end

    assign start_ext = EXT_BITS'(start_reg);
    assign end_ext = EXT_BITS'(offset_next);

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance && emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (!event_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg <= emit_kind;
            start_out_reg <= start_ext[prc_pkg::OUT_OFF_BITS-1:0];
            end_out_reg <= end_ext[prc_pkg::OUT_OFF_BITS-1:0];
        end
    end

    assign event_valid = out_vld_reg;
    assign event_kind = kind_reg;
    assign region_start = start_out_reg;
    assign region_end = end_out_reg;

endmodule

/* rtl/core/png_region_carver.sv */
// Top level of the PNG region carver: byte stream in, region events out.
//
// The stream enters one byte per beat on data_valid/data_byte; the block
// holds off with data_stall. Each byte is captured in an input register and
// compared against the header or trailer signature when the scan stage takes it.
// A finished region, or one abandoned when max_length bytes pass after the
// header, leaves as one beat on event_valid with event_kind, region_start
// and region_end; the receiver holds it with event_stall.
// An accepted byte reaches its event through the input register and then the
// result register; one byte is taken every cycle while that register drains. When the receiver
// stalls a held event, the byte in the input register waits and data_stall
// rises in the same cycle, so at most one byte is buffered inside.
// Signatures and the length limit are written over the APB-style port at
// byte addresses 0, 8 and 16, by the user only while the block is idle (unenforced).
// Reset clears the search phase, the window, the stream offset and the
// counters, restores the default PNG signatures and limit, and drops any
// pending event. No clearing pass is needed.
module png_region_carver
#(
    parameter int unsigned SIG_LEN = 8,
    parameter int unsigned OFFSET_BITS = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [prc_pkg::REG_ADDR_BITS-1:0]   paddr,
    input  logic [prc_pkg::REG_DATA_BITS-1:0]   pwdata,
    output logic [prc_pkg::REG_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    input  logic                                data_valid,
    output logic                                data_stall,
    input  logic [7:0]                          data_byte,
    output logic                                event_valid,
    input  logic                                event_stall,
    output logic                                event_kind,
    output logic [prc_pkg::OUT_OFF_BITS-1:0]    region_start,
    output logic [prc_pkg::OUT_OFF_BITS-1:0]    region_end
);

    prc_pkg::cfg_t  cfg;
    prc_pkg::item_t item;
    logic           advance;

    prc_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    prc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .advance    (advance),
        .item       (item)
    );

    prc_scan
    #(
        .SIG_LEN     (SIG_LEN),
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item         (item),
        .advance      (advance),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_kind   (event_kind),
        .region_start (region_start),
        .region_end   (region_end)
    );

`ifndef SYNTH
    a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> item.vld)
        else $error("Input stalled with no byte held.");

    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!event_valid || !event_stall) |-> !data_stall)
        else $error("Input stalled while the result register could take a beat.");

    a_event_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(event_valid) |-> $past(advance))
        else $error("Event raised without a processed byte.");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the PNG region carver: stream driver, event monitor and predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct packed {
        logic                             kind;
        logic [prc_pkg::OUT_OFF_BITS-1:0] start_off;
        logic [prc_pkg::OUT_OFF_BITS-1:0] stop_off;
    } region_event_t;

    logic                              clk;
    logic                              rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [prc_pkg::REG_ADDR_BITS-1:0] paddr = '0;
    logic [prc_pkg::REG_DATA_BITS-1:0] pwdata = '0;
    logic [prc_pkg::REG_DATA_BITS-1:0] prdata;
    logic                              pready;
    logic                              data_valid = 1'b0;
    logic                              data_stall;
    logic [7:0]                        data_byte = '0;
    logic                              event_valid;
    logic                              event_stall = 1'b0;
    logic                              event_kind;
    logic [prc_pkg::OUT_OFF_BITS-1:0]  region_start;
    logic [prc_pkg::OUT_OFF_BITS-1:0]  region_end;

    logic [63:0]                      hdr_sig = prc_pkg::HEADER_SIG_RESET;
    logic [63:0]                      trl_sig = prc_pkg::TRAILER_SIG_RESET;
    logic [prc_pkg::COUNT_BITS-1:0]   max_len = prc_pkg::MAX_LENGTH_RESET;

    logic                             in_region = 1'b0;
    logic [63:0]                      byte_window = '0;
    logic [prc_pkg::OUT_OFF_BITS-1:0] stream_off = '0;
    logic [prc_pkg::OUT_OFF_BITS-1:0] region_base = '0;
    logic [prc_pkg::COUNT_BITS-1:0]   run_count = '0;

    logic [7:0]    stream_bytes[$];
    region_event_t pending_events[$];
    logic          byte_taken = 1'b0;
    bit            idle_on = 1'b1;
    int            gap_left = 0;
    int            stall_left = 0;
    int            fail_count = 0;
    int unsigned   cycle_count = 0;

    png_region_carver dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .data_byte    (data_byte),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_kind   (event_kind),
        .region_start (region_start),
        .region_end   (region_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advances the carving state by one stream byte and reports an event if one is due.
    function automatic bit carve_byte(input logic [7:0] b, output region_event_t ev);
        logic [prc_pkg::OUT_OFF_BITS-1:0] next_off;
        bit                               full;
        ev = '0;
        byte_window = {byte_window[55:0], b};
        next_off = (stream_off == '1) ? stream_off : stream_off + 1'b1;
        stream_off = next_off;
        if (run_count != '1)
            run_count = run_count + 1'b1;
        full = (run_count >= 8);
        if (!in_region)
        begin
            if (full && byte_window == hdr_sig)
            begin
                region_base = (next_off >= 8) ? next_off - 8 : '0;
                in_region = 1'b1;
                run_count = '0;
            end
            return 1'b0;
        end
        if (full && byte_window == trl_sig)
            ev.kind = prc_pkg::EVENT_COMPLETE;
        else if (run_count >= max_len)
            ev.kind = prc_pkg::EVENT_ABANDONED;
        else
            return 1'b0;
        ev.start_off = region_base;
        ev.stop_off = next_off;
        in_region = 1'b0;
        run_count = '0;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        region_event_t want;
        region_event_t got;
        if (rst_n)
        begin
            if (event_valid && !event_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected event, expected none, actual kind %0d",
                             $time, event_kind);
                    $display("%0t: unexpected event, actual start %0h end %0h",
                             $time, region_start, region_end);
                end
                else
                begin
                    want = pending_events.pop_front();
                    got = '{event_kind, region_start, region_end};
                    if (got.kind !== want.kind)
                    begin
                        fail_count++;
                        $display("%0t: event_kind expected %0d actual %0d",
                                 $time, want.kind, got.kind);
                    end
                    if (got.start_off !== want.start_off)
                    begin
                        fail_count++;
                        $display("%0t: region_start expected %0h actual %0h",
                                 $time, want.start_off, got.start_off);
                    end
                    if (got.stop_off !== want.stop_off)
                    begin
                        fail_count++;
                        $display("%0t: region_end expected %0h actual %0h",
                                 $time, want.stop_off, got.stop_off);
                    end
                end
            end
            if (data_valid && !data_stall)
            begin
                if (carve_byte(data_byte, got))
                    pending_events.push_back(got);
            end
        end
        byte_taken <= data_valid && !data_stall;
    end

    // A stalled beat is held until the block takes it.
    always @(negedge clk)
    begin
        if (!rst_n)
            data_valid <= 1'b0;
        else if (!data_valid || byte_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                data_valid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 2);
                data_valid <= 1'b0;
            end
            else if (stream_bytes.size() > 0)
            begin
                data_byte <= stream_bytes.pop_front();
                data_valid <= 1'b1;
            end
            else
                data_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            event_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            event_stall <= 1'b1;
        end
        else
            event_stall <= 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
    endtask

    task automatic push_sig(input logic [63:0] sig, input int count);
        for (int i = 0; i < count; i++)
            push_byte(sig[63 - 8 * i -: 8]);
    endtask

    // Junk, then mostly a header, body and trailer; some regions are cut short or broken.
    task automatic add_region(input int body_max);
        int shape;
        shape = $urandom_range(0, 9);
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
        if (shape == 0)
        begin
            push_sig(hdr_sig, $urandom_range(1, 7));
            push_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            push_sig(hdr_sig, 8);
            repeat ($urandom_range(0, body_max)) push_byte(8'($urandom_range(0, 255)));
            if (shape == 1)
                push_sig(hdr_sig, 8);
            if (shape == 2)
            begin
                push_sig(trl_sig, $urandom_range(1, 7));
                push_byte(8'($urandom_range(0, 255)));
            end
            if (shape != 3)
                push_sig(trl_sig, 8);
        end
    endtask

    task automatic write_reg(input logic [prc_pkg::REG_IDX_BITS-1:0] idx,
                             input logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            prc_pkg::REG_HEADER_SIG:  hdr_sig = value;
            prc_pkg::REG_TRAILER_SIG: trl_sig = value;
            prc_pkg::REG_MAX_LENGTH:  max_len = value[prc_pkg::COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        while (stream_bytes.size() != 0 || data_valid || pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [63:0] hdr, input logic [63:0] trl,
                             input logic [prc_pkg::COUNT_BITS-1:0] limit,
                             input int bytes_wanted, input int body_max);
        settle();
        write_reg(prc_pkg::REG_HEADER_SIG, hdr);
        write_reg(prc_pkg::REG_TRAILER_SIG, trl);
        write_reg(prc_pkg::REG_MAX_LENGTH, {32'd0, limit});
        while (stream_bytes.size() < bytes_wanted)
            add_region(body_max);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_byte(8'h00);
        push_byte(8'hFF);
        push_sig(hdr_sig, 8);
        push_byte(8'h5A);
        push_sig(trl_sig, 8);

        run_phase(prc_pkg::HEADER_SIG_RESET, prc_pkg::TRAILER_SIG_RESET,
                  prc_pkg::MAX_LENGTH_RESET, 350, 30);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, 32'd1, 100, 4);
        run_phase(64'd0, '1, 32'hFFFF_FFFF, 250, 20);
        begin
            logic [63:0] twin;
            twin = {$urandom, $urandom};
            run_phase(twin, twin, 32'd8, 350, 3);
        end
        run_phase({8{8'h41}}, 64'h4242_4242_4242_4243, 32'($urandom_range(9, 20)), 350, 8);
        settle();
        idle_on = 1'b0;
        run_phase(prc_pkg::HEADER_SIG_RESET, prc_pkg::TRAILER_SIG_RESET,
                  32'($urandom_range(16, 64)), 400, 40);
        settle();

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
